>>> rtl/rc4_pkg.sv
// shared constants and request types for the rc4 stream cipher core
package rc4_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PermDepth = 256;
  localparam int unsigned PermAddrW = $clog2(PermDepth);
  localparam int unsigned KeyMax    = 256;
  localparam int unsigned KeyIdxW   = $clog2(KeyMax);
  localparam int unsigned KeyCntW   = $clog2(KeyMax + 1);

  // stream item kinds carried on tuser
  localparam logic KindKey  = 1'b0;
  localparam logic KindData = 1'b1;

  // permutation store access for one cycle
  typedef struct packed {
    logic                 clr;
    logic                 we;
    logic [PermAddrW-1:0] wr_addr;
    logic [ByteW-1:0]     wr_data;
    logic [PermAddrW-1:0] rd_addr;
  } perm_req_t;

  // key store access for one cycle
  typedef struct packed {
    logic               we;
    logic [KeyIdxW-1:0] wr_addr;
    logic [ByteW-1:0]   wr_data;
    logic [KeyIdxW-1:0] rd_addr;
  } key_req_t;

endpackage

>>> rtl/rc4_stream_cipher_core.sv
// top level of the rc4 stream cipher core
//
// input channel s_axis: one byte per transfer. tuser selects the kind:
// 0 loads a key byte into the key store, 1 is a data byte to encrypt or
// decrypt. tlast on a key byte ends the key and starts the key schedule.
// key bytes beyond 256 are dropped; tlast on a data byte is ignored.
// output channel m_axis: one byte per data transfer, data xor keystream.
// key transfers give no output.
// data path: a data byte passes the states dat_j, dat_swap and dat_out and
// then the output register; the next data byte is not taken before dat_out,
// limited by the single read port of the permutation ram (three reads per byte).
// key schedule: 256 swap steps, each a read state and a swap state, plus one
// closing write; input is held off until the schedule ends after the final key byte.
// reset: permutation reads as identity, indices and key count are zero;
// no clearing pass is needed, per-entry valid bits supply the identity.
// a stalled receiver holds the result in the output register; the core
// finishes the next byte up to its last step and then waits with tready low.
module rc4_stream_cipher_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [rc4_pkg::ByteW-1:0] s_axis_tdata_i,  // [7:0] byte_in
  input  logic                      s_axis_tuser_i,  // [0] kind
  input  logic                      s_axis_tlast_i,  // key_last
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [rc4_pkg::ByteW-1:0] m_axis_tdata_o   // [7:0] byte_out
);

  rc4_pkg::perm_req_t        perm_req;
  rc4_pkg::key_req_t         key_req;
  logic [rc4_pkg::ByteW-1:0] perm_rd;
  logic [rc4_pkg::ByteW-1:0] key_rd;

  // sequencer: handshakes, indices, key schedule steps
  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_kind_i  (s_axis_tuser_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_byte_o (m_axis_tdata_o),
    .perm_req_o (perm_req),
    .perm_rd_i  (perm_rd),
    .key_req_o  (key_req),
    .key_rd_i   (key_rd)
  );

  // permutation table with identity on unwritten entries
  rc4_perm u_perm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (perm_req),
    .rd_data_o(perm_rd)
  );

  // key bytes, read cyclically during the schedule
  rc4_ram #(
    .DataW(rc4_pkg::ByteW),
    .Depth(rc4_pkg::KeyMax)
  ) u_key_ram (
    .clk_i    (clk_i),
    .we_i     (key_req.we),
    .wr_addr_i(key_req.wr_addr),
    .wr_data_i(key_req.wr_data),
    .rd_addr_i(key_req.rd_addr),
    .rd_data_o(key_rd)
  );

endmodule

>>> rtl/rc4_ram.sv
// generic single write port ram with one registered read port, read-first
module rc4_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [DataW-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [DataW-1:0]         rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/rc4_perm.sv
// permutation store: ram plus per-entry valid bits, unwritten entries read as identity
module rc4_perm (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rc4_pkg::perm_req_t       req_i,
  output logic [rc4_pkg::ByteW-1:0] rd_data_o
);

  logic [rc4_pkg::PermDepth-1:0] valid_q;
  logic                          rd_valid_q;
  logic [rc4_pkg::PermAddrW-1:0] rd_addr_q;
  logic [rc4_pkg::ByteW-1:0]     ram_rd_data;

  rc4_ram #(
    .DataW(rc4_pkg::ByteW),
    .Depth(rc4_pkg::PermDepth)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (req_i.we),
    .wr_addr_i(req_i.wr_addr),
    .wr_data_i(req_i.wr_data),
    .rd_addr_i(req_i.rd_addr),
    .rd_data_o(ram_rd_data)
  );

  // clear wins over a write in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[req_i.rd_addr];
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= req_i.rd_addr;
  end

  // address and data are both 8 bits wide
  assign rd_data_o = rd_valid_q ? ram_rd_data : rd_addr_q;

endmodule

>>> rtl/rc4_ctrl.sv
// sequencer for key loading, key schedule and keystream generation
module rc4_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_kind_i,
  input  logic [rc4_pkg::ByteW-1:0] in_byte_i,
  input  logic                      in_last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rc4_pkg::ByteW-1:0] out_byte_o,
  output rc4_pkg::perm_req_t        perm_req_o,
  input  logic [rc4_pkg::ByteW-1:0] perm_rd_i,
  output rc4_pkg::key_req_t         key_req_o,
  input  logic [rc4_pkg::ByteW-1:0] key_rd_i
);

  typedef enum logic [2:0] {
    StIdle,
    StDatJ,
    StDatSwap,
    StDatOut,
    StKsaRd,
    StKsaSwap,
    StKsaFin
  } state_e;

  state_e                      state_q;
  logic [rc4_pkg::ByteW-1:0]   i_q, j_q, a_q, b_q, data_q, jj_q, n_q, ks_q;
  logic [rc4_pkg::KeyIdxW-1:0] kidx_q;
  logic [rc4_pkg::KeyCntW-1:0] kcnt_q;
  logic                        fwd_q;
  logic                        out_valid_q;
  logic [rc4_pkg::ByteW-1:0]   out_byte_q;

  logic                        out_free, accept, key_room;
  logic [rc4_pkg::ByteW-1:0]   j_sum, ks_idx, jj_sum, keystream;
  logic [rc4_pkg::KeyCntW-1:0] kidx_inc;

  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) || ((state_q == StDatOut) && out_free);
  assign accept    = in_valid_i && in_ready_o;
  assign key_room  = kcnt_q < rc4_pkg::KeyCntW'(rc4_pkg::KeyMax);

  assign j_sum     = j_q + perm_rd_i;
  assign ks_idx    = a_q + perm_rd_i;
  assign jj_sum    = jj_q + perm_rd_i + key_rd_i;
  assign kidx_inc  = {1'b0, kidx_q} + rc4_pkg::KeyCntW'(1);
  // keystream byte: forwarded when it lands on the entry being written
  assign keystream = fwd_q ? b_q : perm_rd_i;

  always_comb begin
    perm_req_o         = '0;
    key_req_o          = '0;
    key_req_o.rd_addr  = kidx_q;
    key_req_o.wr_addr  = kcnt_q[rc4_pkg::KeyIdxW-1:0];
    key_req_o.wr_data  = in_byte_i;
    perm_req_o.rd_addr = i_q + rc4_pkg::ByteW'(1);
    if (accept && (in_kind_i == rc4_pkg::KindKey)) begin
      key_req_o.we   = key_room;
      perm_req_o.clr = in_last_i;
    end
    case (state_q)
      StDatJ: begin
        perm_req_o.rd_addr = j_sum;
        perm_req_o.we      = 1'b1;
        perm_req_o.wr_addr = j_sum;
        perm_req_o.wr_data = perm_rd_i;
      end
      StDatSwap: begin
        perm_req_o.rd_addr = ks_idx;
        perm_req_o.we      = 1'b1;
        perm_req_o.wr_addr = i_q;
        perm_req_o.wr_data = perm_rd_i;
      end
      StDatOut: begin
        // keep the keystream entry on the read port while the output waits
        if (!out_free) begin
          perm_req_o.rd_addr = ks_q;
        end
      end
      StKsaRd: begin
        perm_req_o.rd_addr = n_q;
        perm_req_o.we      = (n_q != '0);
        perm_req_o.wr_addr = n_q - rc4_pkg::ByteW'(1);
        perm_req_o.wr_data = perm_rd_i;
      end
      StKsaSwap: begin
        perm_req_o.rd_addr = jj_sum;
        perm_req_o.we      = 1'b1;
        perm_req_o.wr_addr = jj_sum;
        perm_req_o.wr_data = perm_rd_i;
      end
      StKsaFin: begin
        perm_req_o.we      = 1'b1;
        perm_req_o.wr_addr = n_q;
        perm_req_o.wr_data = perm_rd_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      i_q         <= '0;
      j_q         <= '0;
      jj_q        <= '0;
      n_q         <= '0;
      kidx_q      <= '0;
      kcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StDatJ: begin
          j_q     <= j_sum;
          state_q <= StDatSwap;
        end
        StDatSwap: begin
          state_q <= StDatOut;
        end
        StDatOut: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        StKsaRd: begin
          state_q <= StKsaSwap;
        end
        StKsaSwap: begin
          jj_q   <= jj_sum;
          kidx_q <= (kidx_inc == kcnt_q) ? '0 : kidx_inc[rc4_pkg::KeyIdxW-1:0];
          if (n_q == '1) begin
            state_q <= StKsaFin;
          end else begin
            n_q     <= n_q + rc4_pkg::ByteW'(1);
            state_q <= StKsaRd;
          end
        end
        StKsaFin: begin
          i_q     <= '0;
          j_q     <= '0;
          kcnt_q  <= '0;
          state_q <= StIdle;
        end
        default: begin
        end
      endcase
      // a new item may start while the last result is handed off
      if (accept) begin
        if (in_kind_i == rc4_pkg::KindData) begin
          i_q     <= i_q + rc4_pkg::ByteW'(1);
          state_q <= StDatJ;
        end else begin
          if (key_room) begin
            kcnt_q <= kcnt_q + rc4_pkg::KeyCntW'(1);
          end
          if (in_last_i) begin
            n_q     <= '0;
            jj_q    <= '0;
            kidx_q  <= '0;
            state_q <= StKsaRd;
          end else begin
            state_q <= StIdle;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_byte_i;
    end
    if (state_q == StDatJ) begin
      a_q <= perm_rd_i;
    end
    if (state_q == StDatSwap) begin
      b_q   <= perm_rd_i;
      ks_q  <= ks_idx;
      fwd_q <= (ks_idx == i_q);
    end
    if ((state_q == StDatOut) && out_free) begin
      out_byte_q <= data_q ^ keystream;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

>>> rtl/rc4_checker.sv
// port-level checks for the rc4 stream cipher core, bound to the top level
module rc4_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic                      s_axis_tuser_i,
  input logic                      s_axis_tlast_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [rc4_pkg::ByteW-1:0] m_axis_tdata_o
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  // data transfer occupies the ram for the following cycles
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser_i == rc4_pkg::KindData) |=> !s_axis_tready_o)
    else $error("input taken during keystream step");

  // key schedule holds off input
  a_ksa_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser_i == rc4_pkg::KindKey) && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken during key schedule");

  // a fresh result only follows a data transfer that passed dat_j, dat_swap and dat_out
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_xfer && (s_axis_tuser_i == rc4_pkg::KindData), 4))
    else $error("result without matching data transfer");

endmodule

bind rc4_stream_cipher_core rc4_checker u_rc4_checker (.*);
